/* rtl/nte_pkg.sv */
// ----------------------------------------------------------------------------
// Neighbor table engine package
// Table geometry, row and control types, and codes shared by the engine's
// cells, its sequencer and the top level.
// ----------------------------------------------------------------------------
package nte_pkg;

    // Table geometry
    localparam int TABLE_ROWS = 16;
    localparam int ID_BITS    = 16;
    localparam int DATA_BITS  = 64;
    localparam int STAMP_BITS = 32;
    localparam int IDX_BITS   = $clog2(TABLE_ROWS);
    localparam int CNT_BITS   = $clog2(TABLE_ROWS + 1);

    typedef logic [IDX_BITS-1:0]   t_idx;
    typedef logic [CNT_BITS-1:0]   t_cnt;
    typedef logic [ID_BITS-1:0]    t_id;
    typedef logic [DATA_BITS-1:0]  t_data;
    typedef logic [STAMP_BITS-1:0] t_stamp;

    // Timeout register value after reset
    localparam t_stamp STALE_TIMEOUT_RST = t_stamp'(1000);

    // Request function codes
    typedef enum logic [1:0] {
        FN_UPDATE = 2'd0,
        FN_SWEEP  = 2'd1,
        FN_READ   = 2'd2,
        FN_NOP    = 2'd3
    } t_func;

    // Response status codes
    typedef enum logic [1:0] {
        ST_REFRESH = 2'd0,
        ST_INSERT  = 2'd1,
        ST_REPLACE = 2'd2,
        ST_DONE    = 2'd3
    } t_status;

    // Per-cell command
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_LOAD
    } t_cell_cmd;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_WRITE,
        S_SWEEP,
        S_READ,
        S_RESP
    } t_state;

    // One table row
    typedef struct packed {
        t_id    id;
        t_data  data;
        t_stamp stamp;
    } t_row;

    // Sequencer to cell row control
    typedef struct packed {
        logic shift;   // cells at or above ptr take their upper neighbor
        logic load;    // cell at slot takes wr_row
        t_idx ptr;
        t_idx slot;
        t_row wr_row;  // key and tick of the request ride here too
    } t_tbl_ctrl;

    // Response assembled by the sequencer
    typedef struct packed {
        t_status status;
        t_idx    slot;
        t_cnt    row_count;
        t_cnt    removed;
        logic    rd_valid;
        t_row    rd_row;
    } t_result;

endpackage

/* rtl/nte_cell.sv */
// ----------------------------------------------------------------------------
// Neighbor table cell
// Holds one table row. Each cycle it holds, takes its upper neighbor's row
// (compaction) or loads the write bus, and flags a key match and staleness.
// ----------------------------------------------------------------------------
module nte_cell (
    input  logic               i_clk,
    input  nte_pkg::t_cell_cmd i_cmd,
    input  nte_pkg::t_row      i_up,
    input  nte_pkg::t_row      i_wr,
    input  nte_pkg::t_stamp    i_timeout,
    output nte_pkg::t_row      o_row,
    output logic               o_match,
    output logic               o_stale
);

    nte_pkg::t_row   r_row;
    nte_pkg::t_row   n_row;
    nte_pkg::t_stamp w_age;

    // Row update
    always_comb begin
        case (i_cmd)
            nte_pkg::CELL_SHIFT: n_row = i_up;
            nte_pkg::CELL_LOAD:  n_row = i_wr;
            default:             n_row = r_row;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
    end

    // Local flags: key match and wrapped age against the timeout
    assign w_age   = i_wr.stamp - r_row.stamp;
    assign o_match = (r_row.id == i_wr.id);
    assign o_stale = (w_age > i_timeout);
    assign o_row   = r_row;

endmodule

/* rtl/nte_seq.sv */
// ----------------------------------------------------------------------------
// Neighbor table sequencer
// Takes one request at a time, walks the cell row for search, oldest scan and
// compaction, drives the cell commands and builds the response.
// ----------------------------------------------------------------------------
module nte_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_func,
    input  logic [15:0]                     i_sender_id,
    input  logic [63:0]                     i_entry_data,
    input  logic [31:0]                     i_now_tick,
    input  logic [3:0]                      i_read_index,
    input  nte_pkg::t_row                   i_rows [nte_pkg::TABLE_ROWS],
    input  logic [nte_pkg::TABLE_ROWS-1:0]  i_match,
    input  logic [nte_pkg::TABLE_ROWS-1:0]  i_stale,
    output nte_pkg::t_tbl_ctrl              o_ctrl,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output nte_pkg::t_result                o_res
);

    nte_pkg::t_state  r_state, n_state;
    nte_pkg::t_row    r_wr,    n_wr;
    logic [3:0]       r_ridx,  n_ridx;
    nte_pkg::t_cnt    r_used,  n_used;
    nte_pkg::t_cnt    r_ptr,   n_ptr;
    nte_pkg::t_cnt    r_cnt,   n_cnt;
    nte_pkg::t_stamp  r_min,   n_min;
    nte_pkg::t_idx    r_best,  n_best;
    nte_pkg::t_result r_res,   n_res;

    nte_pkg::t_idx    w_p;
    nte_pkg::t_func   w_func;
    logic             w_at_end;

    assign w_p      = nte_pkg::t_idx'(r_ptr);
    assign w_func   = nte_pkg::t_func'(i_func);
    assign w_at_end = (r_ptr == r_used);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            nte_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (w_func)
                        nte_pkg::FN_UPDATE: n_state = nte_pkg::S_SEARCH;
                        nte_pkg::FN_SWEEP:  n_state = nte_pkg::S_SWEEP;
                        nte_pkg::FN_READ:   n_state = nte_pkg::S_READ;
                        default:            n_state = nte_pkg::S_RESP;
                    endcase
                end
            end
            nte_pkg::S_SEARCH: begin
                if (w_at_end || i_match[w_p]) n_state = nte_pkg::S_WRITE;
            end
            nte_pkg::S_WRITE: n_state = nte_pkg::S_RESP;
            nte_pkg::S_SWEEP: begin
                if (r_cnt == '0) n_state = nte_pkg::S_RESP;
            end
            nte_pkg::S_READ: n_state = nte_pkg::S_RESP;
            nte_pkg::S_RESP: begin
                if (i_res_ready) n_state = nte_pkg::S_IDLE;
            end
            default: n_state = nte_pkg::S_IDLE;
        endcase
    end

    // Outputs: handshake and cell commands
    always_comb begin
        o_in_ready         = (r_state == nte_pkg::S_IDLE);
        o_res_valid        = (r_state == nte_pkg::S_RESP);
        o_ctrl.shift       = (r_state == nte_pkg::S_SWEEP) && (r_cnt != '0) && i_stale[w_p];
        o_ctrl.load        = (r_state == nte_pkg::S_WRITE);
        o_ctrl.ptr         = w_p;
        o_ctrl.slot        = r_res.slot;
        o_ctrl.wr_row      = r_wr;
        o_res              = r_res;
    end

    // Datapath
    always_comb begin
        n_wr   = r_wr;
        n_ridx = r_ridx;
        n_used = r_used;
        n_ptr  = r_ptr;
        n_cnt  = r_cnt;
        n_min  = r_min;
        n_best = r_best;
        n_res  = r_res;
        case (r_state)
            nte_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_wr.id        = nte_pkg::t_id'(i_sender_id);
                    n_wr.data      = nte_pkg::t_data'(i_entry_data);
                    n_wr.stamp     = nte_pkg::t_stamp'(i_now_tick);
                    n_ridx         = i_read_index;
                    n_ptr          = '0;
                    n_cnt          = r_used;
                    n_min          = '0;
                    n_best         = '0;
                    n_res          = '0;
                    n_res.status   = nte_pkg::ST_DONE;
                end
            end
            // Walk rows in order: first key match wins, track the oldest
            nte_pkg::S_SEARCH: begin
                if (w_at_end) begin
                    if (r_used < nte_pkg::t_cnt'(nte_pkg::TABLE_ROWS)) begin
                        n_res.slot   = nte_pkg::t_idx'(r_used);
                        n_res.status = nte_pkg::ST_INSERT;
                        n_used       = nte_pkg::t_cnt'(r_used + 1'b1);
                    end else begin
                        n_res.slot   = r_best;
                        n_res.status = nte_pkg::ST_REPLACE;
                    end
                end else if (i_match[w_p]) begin
                    n_res.slot   = w_p;
                    n_res.status = nte_pkg::ST_REFRESH;
                end else begin
                    if ((r_ptr == '0) || (i_rows[w_p].stamp < r_min)) begin
                        n_min  = i_rows[w_p].stamp;
                        n_best = w_p;
                    end
                    n_ptr = nte_pkg::t_cnt'(r_ptr + 1'b1);
                end
            end
            // Compaction: a stale row at ptr is squeezed out by the cells above
            nte_pkg::S_SWEEP: begin
                if (r_cnt == '0) begin
                    n_used = r_ptr;
                end else begin
                    n_cnt = nte_pkg::t_cnt'(r_cnt - 1'b1);
                    if (i_stale[w_p]) begin
                        n_res.removed = nte_pkg::t_cnt'(r_res.removed + 1'b1);
                    end else begin
                        n_ptr = nte_pkg::t_cnt'(r_ptr + 1'b1);
                    end
                end
            end
            nte_pkg::S_READ: begin
                if (32'(r_ridx) < 32'(r_used)) begin
                    n_res.rd_valid = 1'b1;
                    n_res.rd_row   = i_rows[nte_pkg::t_idx'(r_ridx)];
                end
            end
            default: begin
            end
        endcase
        n_res.row_count = n_used;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nte_pkg::S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
        end
    end

    // Request and working payload
    always_ff @(posedge i_clk) begin
        r_wr   <= n_wr;
        r_ridx <= n_ridx;
        r_ptr  <= n_ptr;
        r_cnt  <= n_cnt;
        r_min  <= n_min;
        r_best <= n_best;
        r_res  <= n_res;
    end

endmodule

/* rtl/neighbor_table_engine.sv */
// ----------------------------------------------------------------------------
// Neighbor table engine
// Keyed table of sender rows with oldest-row replacement and timeout sweep.
// ----------------------------------------------------------------------------
// One request is processed at a time; the row of cells is walked one row per
// cycle by the sequencer. An update searches the rows in use, writes the chosen
// row and then offers its response; a sweep compacts the rows in use and then
// offers its response; a read fetches the row and then offers its response,
// and a no-op goes straight to its response. The response sits in an output
// register; the sequencer takes the next request once the response has moved
// into that register, which it does when that register has room.
// No clearing pass is needed after reset: only the row count is cleared, and
// rows beyond it are never read.
// ----------------------------------------------------------------------------
module neighbor_table_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    // Request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_sender_id,
    input  logic [63:0] i_entry_data,
    input  logic [31:0] i_now_tick,
    input  logic [3:0]  i_read_index,
    // Response channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_slot,
    output logic [4:0]  o_row_count,
    output logic [4:0]  o_removed_count,
    output logic        o_read_valid,
    output logic [15:0] o_read_id,
    output logic [63:0] o_read_word,
    output logic [31:0] o_read_stamp
);

    nte_pkg::t_stamp    r_timeout;
    nte_pkg::t_row      w_rows  [nte_pkg::TABLE_ROWS];
    nte_pkg::t_cell_cmd w_cmd   [nte_pkg::TABLE_ROWS];
    logic [nte_pkg::TABLE_ROWS-1:0] w_match;
    logic [nte_pkg::TABLE_ROWS-1:0] w_stale;
    nte_pkg::t_tbl_ctrl w_ctrl;
    logic               w_res_valid;
    logic               w_res_ready;
    nte_pkg::t_result   w_res;
    logic               r_out_valid;
    nte_pkg::t_result   r_out;

    // Timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= nte_pkg::STALE_TIMEOUT_RST;
        end else if (i_cfg_wr_en) begin
            r_timeout <= nte_pkg::t_stamp'(i_cfg_wr_data);
        end
    end

    // Request sequencer
    nte_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_sender_id  (i_sender_id),
        .i_entry_data (i_entry_data),
        .i_now_tick   (i_now_tick),
        .i_read_index (i_read_index),
        .i_rows       (w_rows),
        .i_match      (w_match),
        .i_stale      (w_stale),
        .o_ctrl       (w_ctrl),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res)
    );

    // Row of cells; each hands its row down to the one below on compaction
    for (genvar k = 0; k < nte_pkg::TABLE_ROWS; k++) begin : g_cell
        nte_pkg::t_row w_up;

        always_comb begin
            if (w_ctrl.load && (w_ctrl.slot == nte_pkg::t_idx'(k))) begin
                w_cmd[k] = nte_pkg::CELL_LOAD;
            end else if (w_ctrl.shift && (nte_pkg::t_idx'(k) >= w_ctrl.ptr)) begin
                w_cmd[k] = nte_pkg::CELL_SHIFT;
            end else begin
                w_cmd[k] = nte_pkg::CELL_HOLD;
            end
        end

        if (k == nte_pkg::TABLE_ROWS - 1) begin : g_top
            assign w_up = w_rows[k];
        end else begin : g_mid
            assign w_up = w_rows[k+1];
        end

        nte_cell u_cell (
            .i_clk     (i_clk),
            .i_cmd     (w_cmd[k]),
            .i_up      (w_up),
            .i_wr      (w_ctrl.wr_row),
            .i_timeout (r_timeout),
            .o_row     (w_rows[k]),
            .o_match   (w_match[k]),
            .o_stale   (w_stale[k])
        );
    end

    // Output register
    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_slot          = 4'(r_out.slot);
    assign o_row_count     = 5'(r_out.row_count);
    assign o_removed_count = 5'(r_out.removed);
    assign o_read_valid    = r_out.rd_valid;
    assign o_read_id       = 16'(r_out.rd_row.id);
    assign o_read_word     = 64'(r_out.rd_row.data);
    assign o_read_stamp    = 32'(r_out.rd_row.stamp);

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while previous one still in work");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_row_count) <= nte_pkg::TABLE_ROWS))
        else $error("row count above table size");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_valid) |-> (o_status == nte_pkg::ST_DONE)
            && (o_removed_count == '0) && (o_slot == '0))
        else $error("read hit on a non-read response");

    a_removed_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_removed_count != '0)) |-> (o_status == nte_pkg::ST_DONE)
            && !o_read_valid)
        else $error("rows removed outside a sweep");

endmodule
